// File: rtl/sor_pkg.sv
// Package for segment_overload_removal: payload structs and fixed widths.
// No dependencies.
package sor_pkg;
  localparam int PointW = 8;
  localparam int CapW = 7;

  typedef struct packed {
    logic [7:0] left_end;
    logic [7:0] right_end;
    logic       last_segment;
  } sor_in_t;

  typedef struct packed {
    logic [6:0] removed_index;
    logic       none_removed;
    logic       overflow;
    logic       last_result;
  } sor_out_t;
endpackage

// File: rtl/segment_overload_removal.sv
// Operation: a load reads and writes back each covered point; a last word then sweeps every
// point, and each removal adds a scan of the loaded segments, a read and write back per point
// of its span and a reread; clearing all points ends the job, then the last word strobes.
// Throughput: one word at a time; busy is high while a word is worked.
// Reset: synchronous active-low; coverage memory is cleared by a pass over
// all points after reset. Results cannot be stalled by the receiver.
module segment_overload_removal #(
  parameter int POINT_COUNT = 256,
  parameter int SEGMENT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sor_pkg::sor_in_t  in_word,
  output logic              out_strobe,
  output sor_pkg::sor_out_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  import sor_pkg::*;

  localparam int PW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int SW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam int PX = PW + 1;
  localparam int SX = SW + 1;
  localparam int CW = (PX > 9) ? PX : 9;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_SW_RD, S_SW_CHK, S_SCAN, S_SCAN_CHK,
    S_SUB_RD, S_SUB_WR, S_DONE
  } state_t;

  // storage
  logic [6:0] cov_mem [POINT_COUNT];
  logic [7:0] seg_l [SEGMENT_COUNT];
  logic [7:0] seg_r [SEGMENT_COUNT];
  logic [SEGMENT_COUNT-1:0] removed_r;

  state_t     state_r;
  logic [6:0] cap_r;
  logic [SX-1:0] loaded_r;
  logic       dropped_r;
  logic       last_r;
  logic [PX-1:0] pt_r;       // sweep point
  logic [PX-1:0] wp_r;       // walk point
  logic [PX-1:0] wend_r;     // walk end, inclusive
  logic [6:0] rd_r;          // registered memory read
  logic [7:0] seg_lq_r;      // registered segment reads
  logic [7:0] seg_rq_r;
  logic [SX-1:0] scan_r;
  logic       found_r;
  logic [SW-1:0] best_r;
  logic [7:0] best_lt_r;
  logic [7:0] best_rt_r;
  logic [6:0] cnt_r;
  logic       out_strobe_r;
  logic       strobe_nxt;
  sor_out_t   out_r;
  sor_out_t   pend_r;        // removal waiting for the next one or the job end

  logic mem_we;
  logic [PW-1:0] mem_wa, mem_ra;
  logic [6:0] mem_wd;
  logic seg_we;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word = out_r;

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wp_r[PW-1:0];
    mem_wd = rd_r;
    mem_ra = wp_r[PW-1:0];
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      S_ADD_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_r + 7'd1;
      end
      S_SUB_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_r - 7'd1;
      end
      S_DONE: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      S_SW_RD: mem_ra = pt_r[PW-1:0];
      default: ;
    endcase
  end

  // coverage memory
  always_ff @(posedge clk) begin
    if (mem_we) cov_mem[mem_wa] <= mem_wd;
    rd_r <= cov_mem[mem_ra];
  end

  // segment store: load on accept, read at the scan index
  assign seg_we = rst_n && (state_r == S_IDLE) && start && (loaded_r < SX'(SEGMENT_COUNT));

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_l[loaded_r[SW-1:0]] <= in_word.left_end;
      seg_r[loaded_r[SW-1:0]] <= in_word.right_end;
    end
    seg_lq_r <= seg_l[scan_r[SW-1:0]];
    seg_rq_r <= seg_r[scan_r[SW-1:0]];
  end

  logic       cur_hit;
  assign cur_hit = !removed_r[scan_r[SW-1:0]] && (CW'(seg_lq_r) <= CW'(pt_r))
                   && (CW'(seg_rq_r) >= CW'(pt_r))
                   && (!found_r || seg_rq_r > best_rt_r);

  // strobe a held removal when the next is found, and the last word at job end
  assign strobe_nxt = ((state_r == S_SCAN) && (scan_r >= loaded_r) && found_r &&
                       (cnt_r != 7'd0)) ||
                      ((state_r == S_DONE) && (wp_r == PX'(POINT_COUNT - 1)));

  // clip walk end to the point range
  function automatic logic [PX-1:0] clip_end(input logic [7:0] hi);
    if (CW'(hi) > CW'(POINT_COUNT - 1)) return PX'(POINT_COUNT - 1);
    return PX'(hi);
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      state_r <= S_CLEAR;
      cap_r <= 7'd1;
      loaded_r <= '0;
      dropped_r <= 1'b0;
      removed_r <= '0;
      wp_r <= '0;
    end else begin
      out_strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      case (state_r)
        S_CLEAR: begin
          if (wp_r == PX'(POINT_COUNT - 1)) state_r <= S_IDLE;
          wp_r <= wp_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            last_r <= in_word.last_segment;
            pt_r <= '0;
            cnt_r <= '0;
            if (loaded_r < SX'(SEGMENT_COUNT)) begin
              removed_r[loaded_r[SW-1:0]] <= 1'b0;
              loaded_r <= loaded_r + 1'b1;
              wp_r <= PX'(in_word.left_end);
              wend_r <= clip_end(in_word.right_end);
              if (in_word.right_end >= in_word.left_end &&
                  CW'(in_word.left_end) < CW'(POINT_COUNT))
                state_r <= S_ADD_RD;
              else
                state_r <= in_word.last_segment ? S_SW_RD : S_IDLE;
            end else begin
              dropped_r <= 1'b1;
              state_r <= in_word.last_segment ? S_SW_RD : S_IDLE;
            end
          end
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          wp_r <= wp_r + 1'b1;
          if (wp_r == wend_r) state_r <= last_r ? S_SW_RD : S_IDLE;
          else state_r <= S_ADD_RD;
        end
        S_SW_RD: state_r <= S_SW_CHK;
        S_SW_CHK: begin
          if (rd_r > cap_r && cnt_r < 7'(SEGMENT_COUNT)) begin
            scan_r <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else if (pt_r == PX'(POINT_COUNT - 1)) begin
            wp_r <= '0;
            state_r <= S_DONE;
          end else begin
            pt_r <= pt_r + 1'b1;
            state_r <= S_SW_RD;
          end
        end
        S_SCAN: begin
          if (scan_r < loaded_r) begin
            state_r <= S_SCAN_CHK;
          end else if (!found_r) begin
            if (pt_r == PX'(POINT_COUNT - 1)) begin
              wp_r <= '0;
              state_r <= S_DONE;
            end else begin
              pt_r <= pt_r + 1'b1;
              state_r <= S_SW_RD;
            end
          end else begin
            removed_r[best_r] <= 1'b1;
            wp_r <= PX'(best_lt_r);
            wend_r <= clip_end(best_rt_r);
            // hand the held removal to the output, hold this one
            if (cnt_r != 7'd0) out_r <= pend_r;
            pend_r.removed_index <= 7'(best_r) + 7'd1;
            pend_r.none_removed <= 1'b0;
            pend_r.overflow <= dropped_r;
            pend_r.last_result <= 1'b0;
            cnt_r <= cnt_r + 7'd1;
            state_r <= S_SUB_RD;
          end
        end
        S_SCAN_CHK: begin
          // compare the segment read at the scan index
          if (cur_hit) begin
            found_r <= 1'b1;
            best_r <= scan_r[SW-1:0];
            best_lt_r <= seg_lq_r;
            best_rt_r <= seg_rq_r;
          end
          scan_r <= scan_r + 1'b1;
          state_r <= S_SCAN;
        end
        S_SUB_RD: state_r <= S_SUB_WR;
        S_SUB_WR: begin
          wp_r <= wp_r + 1'b1;
          if (wp_r == wend_r) state_r <= S_SW_RD;
          else state_r <= S_SUB_RD;
        end
        S_DONE: begin
          // clear coverage, then report end of job
          wp_r <= wp_r + 1'b1;
          if (wp_r == PX'(POINT_COUNT - 1)) begin
            if (cnt_r == 7'd0) begin
              out_r.removed_index <= '0;
              out_r.none_removed <= 1'b1;
              out_r.overflow <= dropped_r;
              out_r.last_result <= 1'b1;
            end else begin
              out_r.removed_index <= pend_r.removed_index;
              out_r.none_removed <= pend_r.none_removed;
              out_r.overflow <= pend_r.overflow;
              out_r.last_result <= 1'b1;
            end
            removed_r <= '0;
            loaded_r <= '0;
            dropped_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
